/* sv/hud_pkg.sv */
// Shared types and constants for the HCI UART packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package hud_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] AclCodeRst = 8'd2;
  localparam logic [ByteW-1:0] EvtCodeRst = 8'd4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAclIdx = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgEvtIdx = 1'b1;

  // Packet kinds
  localparam logic KindEvt = 1'b0;
  localparam logic KindAcl = 1'b1;

  typedef enum logic [1:0] {
    CLS_TYPE = 2'd0,
    CLS_DROP = 2'd1,
    CLS_HEAD = 2'd2,
    CLS_BODY = 2'd3
  } byte_class_e;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    byte_class_e      byte_class;
    logic             packet_kind;
    logic [LenW-1:0]  payload_length;
    logic             end_of_packet;
  } hud_result_t;

endpackage
`default_nettype wire

/* sv/hud_deframer.sv */
// Per-byte deframing state and labelling logic.
`timescale 1ns / 1ps
`default_nettype none
module hud_deframer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire logic [hud_pkg::ByteW-1:0]  byte_i,
  input  wire logic [hud_pkg::ByteW-1:0]  acl_code_i,
  input  wire logic [hud_pkg::ByteW-1:0]  evt_code_i,
  output hud_pkg::hud_result_t            result_o
);

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_HEAD,
    PH_BODY
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic                       kind_q, kind_d;
  logic [1:0]                 hcnt_q, hcnt_d;
  logic [hud_pkg::LenW-1:0]   pcnt_q, pcnt_d;
  logic [hud_pkg::LenW-1:0]   len_q, len_d;
  logic [hud_pkg::LenW-1:0]   pcnt_inc;
  logic                       last_head;
  logic                       acl_hit, evt_hit;

  assign pcnt_inc  = pcnt_q + hud_pkg::LenW'(1);
  assign last_head = (kind_q == hud_pkg::KindAcl) ? (hcnt_q == 2'd3) : (hcnt_q == 2'd1);
  assign acl_hit   = (byte_i == acl_code_i);
  assign evt_hit   = (byte_i == evt_code_i);

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    hcnt_d  = hcnt_q;
    pcnt_d  = pcnt_q;
    len_d   = len_q;
    result_o.byte_out       = byte_i;
    result_o.byte_class     = hud_pkg::CLS_DROP;
    result_o.packet_kind    = hud_pkg::KindEvt;
    result_o.payload_length = '0;
    result_o.end_of_packet  = 1'b0;
    unique case (phase_q)
      PH_HEAD: begin
        result_o.byte_class  = hud_pkg::CLS_HEAD;
        result_o.packet_kind = kind_q;
        if (kind_q == hud_pkg::KindAcl) begin
          if (hcnt_q == 2'd2) begin
            len_d[7:0] = byte_i;
          end else if (hcnt_q == 2'd3) begin
            len_d[15:8] = byte_i;
          end
        end else if (hcnt_q == 2'd1) begin
          len_d = {8'h00, byte_i};
        end
        hcnt_d = hcnt_q + 2'd1;
        if (last_head) begin
          result_o.payload_length = len_d;
          pcnt_d = '0;
          if (len_d == '0) begin
            result_o.end_of_packet = 1'b1;
            phase_d = PH_TYPE;
            hcnt_d  = '0;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        result_o.byte_class     = hud_pkg::CLS_BODY;
        result_o.packet_kind    = kind_q;
        result_o.payload_length = len_q;
        pcnt_d = pcnt_inc;
        if (pcnt_inc == len_q) begin
          result_o.end_of_packet = 1'b1;
          phase_d = PH_TYPE;
          hcnt_d  = '0;
          pcnt_d  = '0;
        end
      end
      default: begin
        if (acl_hit || evt_hit) begin
          // ACL code wins when both codes match
          kind_d  = acl_hit ? hud_pkg::KindAcl : hud_pkg::KindEvt;
          result_o.byte_class  = hud_pkg::CLS_TYPE;
          result_o.packet_kind = kind_d;
          phase_d = PH_HEAD;
          hcnt_d  = '0;
          pcnt_d  = '0;
          len_d   = '0;
        end else begin
          phase_d = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      kind_q  <= 1'b0;
      hcnt_q  <= '0;
      pcnt_q  <= '0;
      len_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      hcnt_q  <= hcnt_d;
      pcnt_q  <= pcnt_d;
      len_q   <= len_d;
    end
  end

endmodule
`default_nettype wire

/* sv/hud_out_reg.sv */
// Result register with valid/stall handshake toward the consumer.
`timescale 1ns / 1ps
`default_nettype none
module hud_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire hud_pkg::hud_result_t result_i,
  input  wire logic                 stall_i,
  output logic                      valid_o,
  output logic                      ready_o,
  output hud_pkg::hud_result_t      result_o
);

  logic                 valid_q;
  hud_pkg::hud_result_t data_q;

  // Take a new result when empty or when the held one transfers now
  assign ready_o  = !valid_q || !stall_i;
  assign valid_o  = valid_q;
  assign result_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= result_i;
    end
  end

endmodule
`default_nettype wire

/* sv/hci_uart_packet_deframer_core.sv */
// Top level of the HCI UART (H4) packet deframer.
// Path: input register, combinational labelling, then the result register.
// Throughput: one byte per cycle unless out_stall_i holds; the input and
//   result registers each hold one byte, so input stalls only when both fill.
// Reset: asynchronous, active low; clears handshake state, deframer state
//   (waiting for a type byte) and sets type codes to ACL 2 / event 4.
`timescale 1ns / 1ps
`default_nettype none
module hci_uart_packet_deframer_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [hud_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [hud_pkg::ByteW-1:0]    cfg_data_i,
  // byte input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [hud_pkg::ByteW-1:0]    rx_byte_i,
  // labelled byte output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [hud_pkg::ByteW-1:0]         byte_out_o,
  output logic [1:0]                        byte_class_o,
  output logic                              packet_kind_o,
  output logic [hud_pkg::LenW-1:0]          payload_length_o,
  output logic                              end_of_packet_o
);

  logic [hud_pkg::ByteW-1:0] acl_code_q;
  logic [hud_pkg::ByteW-1:0] evt_code_q;

  logic                      in_vld_q;
  logic [hud_pkg::ByteW-1:0] in_byte_q;

  logic                      out_ready;
  logic                      fire;
  hud_pkg::hud_result_t      res_comb;
  hud_pkg::hud_result_t      res_q;

  // Type code registers; the user must write them only while the block is idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acl_code_q <= hud_pkg::AclCodeRst;
      evt_code_q <= hud_pkg::EvtCodeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hud_pkg::CfgAclIdx: acl_code_q <= cfg_data_i;
        hud_pkg::CfgEvtIdx: evt_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the held byte into the deframer whenever the result register
  // can take it; this both labels the byte and updates the packet state.
  assign fire       = in_vld_q && out_ready;
  // Stall only when the input register is full and cannot drain this cycle
  assign in_stall_o = in_vld_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Hold the byte payload on transfer only
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  hud_deframer u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (in_byte_q),
    .acl_code_i (acl_code_q),
    .evt_code_i (evt_code_q),
    .result_o   (res_comb)
  );

  hud_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_vld_q),
    .result_i (res_comb),
    .stall_i  (out_stall_i),
    .valid_o  (out_valid_o),
    .ready_o  (out_ready),
    .result_o (res_q)
  );

  assign byte_out_o       = res_q.byte_out;
  assign byte_class_o     = res_q.byte_class;
  assign packet_kind_o    = res_q.packet_kind;
  assign payload_length_o = res_q.payload_length;
  assign end_of_packet_o  = res_q.end_of_packet;

endmodule
`default_nettype wire

/* sv/hud_checker.sv */
// Port-level checker for the deframer top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none
module hud_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [hud_pkg::ByteW-1:0]   byte_out_o,
  input wire logic [1:0]                  byte_class_o,
  input wire logic                        packet_kind_o,
  input wire logic [hud_pkg::LenW-1:0]    payload_length_o,
  input wire logic                        end_of_packet_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_out_o)
      && $stable(byte_class_o) && $stable(payload_length_o)
      && $stable(end_of_packet_o))
    else $error("stalled result changed");

  // Dropped bytes carry no packet information
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_class_o == hud_pkg::CLS_DROP |->
      !packet_kind_o && payload_length_o == '0 && !end_of_packet_o)
    else $error("dropped byte carries packet fields");

  // A type byte never ends a packet and shows no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_class_o == hud_pkg::CLS_TYPE |->
      payload_length_o == '0 && !end_of_packet_o)
    else $error("type byte with length or end mark");

  // A payload byte always reports a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_class_o == hud_pkg::CLS_BODY |-> payload_length_o != '0)
    else $error("payload byte with zero length");

endmodule

bind hci_uart_packet_deframer_core hud_checker u_hud_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .byte_out_o       (byte_out_o),
  .byte_class_o     (byte_class_o),
  .packet_kind_o    (packet_kind_o),
  .payload_length_o (payload_length_o),
  .end_of_packet_o  (end_of_packet_o)
);
`default_nettype wire

/* tb/sv/hud_deframer_checker.sv */
// Checker for the HCI UART deframer: predicts the label of every byte and compares results.
`timescale 1ns / 1ps
module hud_deframer_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [hud_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [hud_pkg::ByteW-1:0]   cfg_data_i,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_stall_i,
  input  wire logic [hud_pkg::ByteW-1:0]   rx_byte_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_stall_i,
  input  wire logic [hud_pkg::ByteW-1:0]   byte_out_i,
  input  wire logic [1:0]                  byte_class_i,
  input  wire logic                        packet_kind_i,
  input  wire logic [hud_pkg::LenW-1:0]    payload_length_i,
  input  wire logic                        end_of_packet_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               checked_o,
  output int                               packets_o
);

  localparam logic [2:0] EvtHeadBytes = 3'd2;
  localparam logic [2:0] AclHeadBytes = 3'd4;

  typedef enum logic [2:0] {
    WAIT_TYPE  = 3'd0,
    IN_HEADER  = 3'd1,
    IN_PAYLOAD = 3'd2
  } frame_phase_e;

  logic [hud_pkg::ByteW-1:0] acl_code = hud_pkg::AclCodeRst;
  logic [hud_pkg::ByteW-1:0] evt_code = hud_pkg::EvtCodeRst;

  frame_phase_e             phase       = WAIT_TYPE;
  logic                     cur_kind    = hud_pkg::KindEvt;
  logic [2:0]               hdr_taken   = '0;
  logic [hud_pkg::LenW-1:0] body_taken  = '0;
  logic [hud_pkg::LenW-1:0] len_capture = '0;

  hud_pkg::hud_result_t label_queue[$];

  function automatic void return_to_type();
    phase      = WAIT_TYPE;
    hdr_taken  = '0;
    body_taken = '0;
  endfunction

  // Label one byte and advance the framing state.
  function automatic hud_pkg::hud_result_t label_byte(input logic [hud_pkg::ByteW-1:0] b);
    hud_pkg::hud_result_t r;
    logic [2:0]           next_hdr;
    logic [2:0]           hdr_total;
    r.byte_out       = b;
    r.byte_class     = hud_pkg::CLS_DROP;
    r.packet_kind    = hud_pkg::KindEvt;
    r.payload_length = '0;
    r.end_of_packet  = 1'b0;
    case (phase)
      IN_HEADER: begin
        hdr_total     = (cur_kind == hud_pkg::KindAcl) ? AclHeadBytes : EvtHeadBytes;
        r.byte_class  = hud_pkg::CLS_HEAD;
        r.packet_kind = cur_kind;
        if (cur_kind == hud_pkg::KindAcl) begin
          if (hdr_taken == 3'd2) len_capture[7:0] = b;
          else if (hdr_taken == 3'd3) len_capture[15:8] = b;
        end else if (hdr_taken == 3'd1) begin
          len_capture = {8'h00, b};
        end
        next_hdr  = hdr_taken + 3'd1;
        hdr_taken = next_hdr;
        if (next_hdr >= hdr_total) begin
          r.payload_length = len_capture;
          body_taken       = '0;
          // empty packet closes on its last header byte
          if (len_capture == '0) begin
            r.end_of_packet = 1'b1;
            return_to_type();
          end else begin
            phase = IN_PAYLOAD;
          end
        end
      end
      IN_PAYLOAD: begin
        r.byte_class     = hud_pkg::CLS_BODY;
        r.packet_kind    = cur_kind;
        r.payload_length = len_capture;
        body_taken       = body_taken + hud_pkg::LenW'(1);
        if (body_taken == len_capture) begin
          r.end_of_packet = 1'b1;
          return_to_type();
        end
      end
      default: begin
        // ACL code wins when both codes match
        if (b == acl_code || b == evt_code) begin
          cur_kind      = (b == acl_code) ? hud_pkg::KindAcl : hud_pkg::KindEvt;
          r.byte_class  = hud_pkg::CLS_TYPE;
          r.packet_kind = cur_kind;
          phase         = IN_HEADER;
          hdr_taken     = '0;
          body_taken    = '0;
          len_capture   = '0;
        end else begin
          phase = WAIT_TYPE;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void note_mismatch(input string what,
                                        input logic [hud_pkg::LenW-1:0] want_v,
                                        input logic [hud_pkg::LenW-1:0] got_v);
    fail_count_o++;
    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want_v, got_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hud_pkg::hud_result_t want;
    if (!rst_ni) begin
      acl_code    = hud_pkg::AclCodeRst;
      evt_code    = hud_pkg::EvtCodeRst;
      phase       = WAIT_TYPE;
      cur_kind    = hud_pkg::KindEvt;
      hdr_taken   = '0;
      body_taken  = '0;
      len_capture = '0;
      label_queue.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hud_pkg::CfgAclIdx: acl_code = cfg_data_i;
          hud_pkg::CfgEvtIdx: evt_code = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) label_queue.push_back(label_byte(rx_byte_i));
      if (out_valid_i && !out_stall_i) begin
        if (label_queue.size() == 0) begin
          note_mismatch("unexpected result byte", '0, {8'h00, byte_out_i});
        end else begin
          want = label_queue.pop_front();
          if (want.byte_out !== byte_out_i)
            note_mismatch("byte_out", hud_pkg::LenW'(want.byte_out),
                          hud_pkg::LenW'(byte_out_i));
          if (want.byte_class !== byte_class_i)
            note_mismatch("byte_class", hud_pkg::LenW'(want.byte_class),
                          hud_pkg::LenW'(byte_class_i));
          if (want.packet_kind !== packet_kind_i)
            note_mismatch("packet_kind", hud_pkg::LenW'(want.packet_kind),
                          hud_pkg::LenW'(packet_kind_i));
          if (want.payload_length !== payload_length_i)
            note_mismatch("payload_length", want.payload_length, payload_length_i);
          if (want.end_of_packet !== end_of_packet_i)
            note_mismatch("end_of_packet", hud_pkg::LenW'(want.end_of_packet),
                          hud_pkg::LenW'(end_of_packet_i));
          checked_o++;
          if (want.end_of_packet) packets_o++;
        end
      end
      pending_o <= label_queue.size();
    end
  end

endmodule

/* tb/sv/tb_hci_uart_packet_deframer_core.sv */
// Testbench top for the HCI UART packet deframer: clock, reset, byte stream and verdict.
`timescale 1ns / 1ps
module tb_hci_uart_packet_deframer_core;

  localparam int HalfPeriod = 2;
  localparam int IdlePct    = 38;
  localparam int HoldCycles = 60;

  // Block inputs, all known from time zero.
  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [hud_pkg::CfgIdxW-1:0] cfg_idx_i   = hud_pkg::CfgAclIdx;
  logic [hud_pkg::ByteW-1:0]   cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic [hud_pkg::ByteW-1:0]   rx_byte_i   = '0;
  logic                        out_stall_i = 1'b0;

  // Block outputs.
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [hud_pkg::ByteW-1:0]   byte_out_o;
  logic [1:0]                  byte_class_o;
  logic                        packet_kind_o;
  logic [hud_pkg::LenW-1:0]    payload_length_o;
  logic                        end_of_packet_o;

  // Checker status.
  int fail_count;
  int pending;
  int checked;
  int packets;

  // Stimulus bookkeeping.
  int                        items_sent    = 0;
  int                        settings_used = 1;
  int                        hold_req      = 0;
  int                        hold_seen     = 0;
  int                        hold_left     = 0;
  bit                        no_idle       = 1'b0;
  logic [hud_pkg::ByteW-1:0] acl_code      = hud_pkg::AclCodeRst;
  logic [hud_pkg::ByteW-1:0] evt_code      = hud_pkg::EvtCodeRst;

  hci_uart_packet_deframer_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .byte_out_o       (byte_out_o),
    .byte_class_o     (byte_class_o),
    .packet_kind_o    (packet_kind_o),
    .payload_length_o (payload_length_o),
    .end_of_packet_o  (end_of_packet_o)
  );

  hud_deframer_checker u_label_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .byte_out_i       (byte_out_o),
    .byte_class_i     (byte_class_o),
    .packet_kind_i    (packet_kind_o),
    .payload_length_i (payload_length_o),
    .end_of_packet_i  (end_of_packet_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .packets_o        (packets)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Result side: stall at random, hold off for a long stretch whenever the
  // stimulus bumps hold_req, and never stall at random while no_idle is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Offer one byte and return at the edge where its transfer happens. Idle
  // cycles come first so that valid is raised only once per item; the byte
  // holds still while the block stalls.
  task automatic send_byte(input logic [hud_pkg::ByteW-1:0] b);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Drop valid and wait until every labelled byte has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write both type codes on back-to-back edges, ACL first; call only while idle.
  task automatic set_codes(input logic [hud_pkg::ByteW-1:0] acl,
                           input logic [hud_pkg::ByteW-1:0] evt);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= hud_pkg::CfgAclIdx;
    cfg_data_i <= acl;
    @(posedge clk_i);
    cfg_idx_i  <= hud_pkg::CfgEvtIdx;
    cfg_data_i <= evt;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    acl_code = acl;
    evt_code = evt;
    settings_used++;
  endtask

  // Mostly short payloads, a few empty ones, and now and then a long one
  // that sets the high length byte (ACL) or the largest event length.
  function automatic logic [hud_pkg::LenW-1:0] pick_length(input logic acl);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 70) return hud_pkg::LenW'($urandom_range(1, 12));
    if (roll < 97) return hud_pkg::LenW'($urandom_range(13, 80));
    return acl ? hud_pkg::LenW'($urandom_range(256, 300)) : hud_pkg::LenW'(255);
  endfunction

  // Send one well-formed frame with random header filler and payload.
  task automatic send_packet(input logic acl, input logic [hud_pkg::LenW-1:0] len);
    send_byte(acl ? acl_code : evt_code);
    send_byte(hud_pkg::ByteW'($urandom));
    if (acl) begin
      send_byte(hud_pkg::ByteW'($urandom));
      send_byte(len[7:0]);
      send_byte(len[15:8]);
    end else begin
      send_byte(len[7:0]);
    end
    repeat (len) send_byte(hud_pkg::ByteW'($urandom));
  endtask

  // Random traffic: mostly frames, some stray bytes and some cut-off event
  // headers that knock the framing out of step for a while.
  task automatic run_traffic(input int count);
    int                        stop_at;
    int unsigned               roll;
    logic                      acl;
    logic [hud_pkg::ByteW-1:0] b;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        repeat ($urandom_range(1, 3)) begin
          b = hud_pkg::ByteW'($urandom);
          // keep stray bytes from opening ACL frames with huge random lengths
          if (b == acl_code) b = b ^ 8'h80;
          send_byte(b);
        end
      end else if (roll < 15 && acl_code != evt_code) begin
        send_byte(evt_code);
        repeat ($urandom_range(0, 1)) send_byte(hud_pkg::ByteW'($urandom));
      end else begin
        acl = (acl_code == evt_code) ? hud_pkg::KindAcl
                                     : hud_pkg::KindAcl ^ 1'($urandom_range(0, 1));
        send_packet(acl, pick_length(acl));
      end
    end
  endtask

  initial begin
    // Opening stream under reset codes (ACL 2, event 4): stray bytes at both
    // ends of the range, an event frame, an empty event frame, an ACL frame
    // and an empty ACL frame.
    logic [hud_pkg::ByteW-1:0] opening [24] = '{
      8'h00, 8'hFF, 8'h03,
      8'h04, 8'hAA, 8'h03, 8'hFF, 8'h00, 8'h55,
      8'h04, 8'h0E, 8'h00,
      8'h02, 8'h01, 8'h20, 8'h02, 8'h00, 8'h80, 8'h7F,
      8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00
    };
    logic [hud_pkg::ByteW-1:0] rnd_acl;
    logic [hud_pkg::ByteW-1:0] rnd_evt;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i]);

    // Hold off the result side while bytes keep coming, so both internal
    // registers fill and the input stalls; then pause until drained.
    run_traffic(60);
    hold_req++;
    run_traffic(60);
    wait_all_results();
    run_traffic(40);
    wait_all_results();

    // Extreme codes, first with no idling on either side.
    set_codes(8'h00, 8'hFF);
    no_idle = 1'b1;
    run_traffic(80);
    no_idle = 1'b0;
    run_traffic(40);
    wait_all_results();

    set_codes(8'hFF, 8'h00);
    run_traffic(70);
    wait_all_results();

    // Equal codes: the type byte must open an ACL frame.
    set_codes(8'h5A, 8'h5A);
    run_traffic(70);
    wait_all_results();

    repeat (2) begin
      rnd_acl = hud_pkg::ByteW'($urandom);
      rnd_evt = hud_pkg::ByteW'($urandom);
      if (rnd_evt == rnd_acl) rnd_evt = ~rnd_acl;
      set_codes(rnd_acl, rnd_evt);
      run_traffic(70);
      wait_all_results();
    end

    // Long frames of both kinds (largest event length, ACL length with the
    // high byte set), then a last stretch of mixed traffic.
    set_codes(hud_pkg::AclCodeRst, hud_pkg::EvtCodeRst);
    send_packet(hud_pkg::KindEvt, 16'd255);
    no_idle = 1'b1;
    send_packet(hud_pkg::KindAcl, 16'h0100);
    no_idle = 1'b0;
    run_traffic(40);
    wait_all_results();

    repeat (4) @(posedge clk_i);
    $display("Run covered %0d bytes under %0d type-code settings:", items_sent, settings_used);
    $display("%0d labels checked, %0d packets closed.", checked, packets);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hang: the slowest correct run is well under a tenth of this.
  initial begin
    #(3_000_000);
    $display("Timeout with %0d labels still outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/hud_pkg.sv
sv/hud_deframer.sv
sv/hud_out_reg.sv
sv/hci_uart_packet_deframer_core.sv
sv/hud_checker.sv
tb/sv/hud_deframer_checker.sv
tb/sv/tb_hci_uart_packet_deframer_core.sv
